>>> rtl/core/nirt_pkg.sv
// Shared types, register indexes and reset values of the NEC infrared frame transmitter.
package nirt_pkg;

	// Duration registers are all this wide
	localparam int unsigned DUR_W = 10;
	localparam int unsigned CFG_IDX_W = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MARK    = 3'd5;

	// Reset durations in carrier periods
	localparam logic [DUR_W-1:0] RST_LEADER_MARK  = 10'd341;
	localparam logic [DUR_W-1:0] RST_LEADER_SPACE = 10'd170;
	localparam logic [DUR_W-1:0] RST_BIT_MARK     = 10'd20;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 10'd63;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 10'd20;
	localparam logic [DUR_W-1:0] RST_STOP_MARK    = 10'd20;

	// Item mode codes
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;

	typedef struct packed {
		logic [DUR_W-1:0] leader_mark_ticks;
		logic [DUR_W-1:0] leader_space_ticks;
		logic [DUR_W-1:0] bit_mark_ticks;
		logic [DUR_W-1:0] one_space_ticks;
		logic [DUR_W-1:0] zero_space_ticks;
		logic [DUR_W-1:0] stop_mark_ticks;
	} cfg_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
	} item_t;

	typedef struct packed {
		logic carrier_on;
		logic busy_res;
		logic receiver_enable;
		logic frame_done;
		logic start_rejected;
	} result_t;

	typedef enum logic [5:0] {
		PH_IDLE       = 6'b000001,
		PH_LEAD_MARK  = 6'b000010,
		PH_LEAD_SPACE = 6'b000100,
		PH_BIT_MARK   = 6'b001000,
		PH_BIT_SPACE  = 6'b010000,
		PH_STOP_MARK  = 6'b100000
	} phase_t;

endpackage

>>> rtl/core/nirt_item_if.sv
// Input channel: valid/ready handshake carrying one tick or start item.
interface nirt_item_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;

	modport source (output valid, mode, first_byte, second_byte, third_byte, input ready);
	modport sink   (input valid, mode, first_byte, second_byte, third_byte, output ready);
endinterface

>>> rtl/core/nirt_res_if.sv
// Result channel: valid/ready handshake carrying one result per item.
interface nirt_res_if;
	logic valid;
	logic ready;
	logic carrier_on;
	logic busy_res;
	logic receiver_enable;
	logic frame_done;
	logic start_rejected;

	modport source (output valid, carrier_on, busy_res, receiver_enable, frame_done,
		start_rejected, input ready);
	modport sink   (input valid, carrier_on, busy_res, receiver_enable, frame_done,
		start_rejected, output ready);
endinterface

>>> rtl/core/nirt_cfg_regs.sv
// Duration register file written through the plain configuration port.
module nirt_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [nirt_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [nirt_pkg::DUR_W-1:0]       wr_data,
	output nirt_pkg::cfg_t                   cfg
);

	nirt_pkg::cfg_t cfg_q;

	// Write the addressed register; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_mark_ticks  <= nirt_pkg::RST_LEADER_MARK;
			cfg_q.leader_space_ticks <= nirt_pkg::RST_LEADER_SPACE;
			cfg_q.bit_mark_ticks     <= nirt_pkg::RST_BIT_MARK;
			cfg_q.one_space_ticks    <= nirt_pkg::RST_ONE_SPACE;
			cfg_q.zero_space_ticks   <= nirt_pkg::RST_ZERO_SPACE;
			cfg_q.stop_mark_ticks    <= nirt_pkg::RST_STOP_MARK;
		end else if (wr_en) begin
			case (wr_index)
				nirt_pkg::REG_LEADER_MARK:  cfg_q.leader_mark_ticks  <= wr_data;
				nirt_pkg::REG_LEADER_SPACE: cfg_q.leader_space_ticks <= wr_data;
				nirt_pkg::REG_BIT_MARK:     cfg_q.bit_mark_ticks     <= wr_data;
				nirt_pkg::REG_ONE_SPACE:    cfg_q.one_space_ticks    <= wr_data;
				nirt_pkg::REG_ZERO_SPACE:   cfg_q.zero_space_ticks   <= wr_data;
				nirt_pkg::REG_STOP_MARK:    cfg_q.stop_mark_ticks    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/nirt_frame_core.sv
// Frame sequencer: phase, period counter, bit counter and payload shift register.
module nirt_frame_core #(
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  nirt_pkg::item_t   item,
	input  nirt_pkg::cfg_t    cfg,
	output nirt_pkg::result_t res
);

	localparam int unsigned BIDX_W = $clog2(PAYLOAD_BITS + 1);
	localparam logic [BIDX_W-1:0] LAST_BIT = BIDX_W'(PAYLOAD_BITS - 1);

	nirt_pkg::phase_t            phase_q, phase_d;
	logic [nirt_pkg::DUR_W-1:0]  count_q, count_d, count_inc, len;
	logic [BIDX_W-1:0]           bidx_q, bidx_d;
	logic [PAYLOAD_BITS-1:0]     shift_q, shift_d;
	logic [31:0]                 word;
	logic                        carrier, done, rejected, busy;

	// Payload word: three bytes and the inverse of the third, LSB first
	assign word = {~item.third_byte, item.third_byte, item.second_byte, item.first_byte};
	assign count_inc = count_q + 1'b1;

	// Length of the current phase; the bit under transmission sits at shift_q[0]
	always_comb begin
		case (phase_q)
			nirt_pkg::PH_LEAD_MARK:  len = cfg.leader_mark_ticks;
			nirt_pkg::PH_LEAD_SPACE: len = cfg.leader_space_ticks;
			nirt_pkg::PH_BIT_MARK:   len = cfg.bit_mark_ticks;
			nirt_pkg::PH_BIT_SPACE:  len = shift_q[0] ? cfg.one_space_ticks
				: cfg.zero_space_ticks;
			nirt_pkg::PH_STOP_MARK:  len = cfg.stop_mark_ticks;
			default:                 len = nirt_pkg::DUR_W'(1);
		endcase
	end

	// Next state and result for the item in the input register
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		bidx_d   = bidx_q;
		shift_d  = shift_q;
		carrier  = 1'b0;
		done     = 1'b0;
		rejected = 1'b0;
		if (item.mode == nirt_pkg::MODE_START) begin
			if (phase_q != nirt_pkg::PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				shift_d = PAYLOAD_BITS'(word);
				phase_d = nirt_pkg::PH_LEAD_MARK;
				count_d = '0;
				bidx_d  = '0;
			end
		end else if (phase_q != nirt_pkg::PH_IDLE) begin
			carrier = (phase_q == nirt_pkg::PH_LEAD_MARK) || (phase_q == nirt_pkg::PH_BIT_MARK)
				|| (phase_q == nirt_pkg::PH_STOP_MARK);
			if (count_inc >= len) begin
				count_d = '0;
				case (phase_q)
					nirt_pkg::PH_LEAD_MARK:  phase_d = nirt_pkg::PH_LEAD_SPACE;
					nirt_pkg::PH_LEAD_SPACE: phase_d = nirt_pkg::PH_BIT_MARK;
					nirt_pkg::PH_BIT_MARK:   phase_d = nirt_pkg::PH_BIT_SPACE;
					nirt_pkg::PH_BIT_SPACE: begin
						bidx_d  = bidx_q + 1'b1;
						shift_d = shift_q >> 1;
						phase_d = (bidx_q == LAST_BIT) ? nirt_pkg::PH_STOP_MARK
							: nirt_pkg::PH_BIT_MARK;
					end
					nirt_pkg::PH_STOP_MARK: begin
						phase_d = nirt_pkg::PH_IDLE;
						bidx_d  = '0;
						done    = 1'b1;
					end
					default: phase_d = nirt_pkg::PH_IDLE;
				endcase
			end else begin
				count_d = count_inc;
			end
		end
		busy = (phase_d != nirt_pkg::PH_IDLE);
	end

	// Advance the sequencer once per transfer leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nirt_pkg::PH_IDLE;
			count_q <= '0;
			bidx_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			bidx_q  <= bidx_d;
		end
	end

	// Payload shift register holds data only
	always_ff @(posedge clk) begin
		if (step) begin
			shift_q <= shift_d;
		end
	end

	assign res.carrier_on      = carrier;
	assign res.busy_res        = busy;
	assign res.receiver_enable = ~busy;
	assign res.frame_done      = done;
	assign res.start_rejected  = rejected;

endmodule

>>> rtl/core/nec_ir_frame_transmitter.sv
// NEC infrared frame transmitter top level: input register, sequencer, result register.
// Each item is either one carrier-period tick or a frame start carrying three
// payload bytes. Every item produces exactly one result. The input register
// (stage 1) feeds the sequencer, whose phase, period and bit counters advance
// as the item leaves it, and the result is held in the result register (stage 2)
// until transferred. A new item can be taken every cycle; a stalled result stops
// stage 1 only when both stages are full. The user writes durations through the
// wr_en/wr_index/wr_data port only while idle; the block does not enforce it.
module nec_ir_frame_transmitter #(
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	nirt_item_if.sink                      item,
	nirt_res_if.source                     result,
	input  logic                           wr_en,
	input  logic [nirt_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [nirt_pkg::DUR_W-1:0]     wr_data
);

	nirt_pkg::cfg_t    cfg;
	nirt_pkg::item_t   item_s1;
	nirt_pkg::result_t res_d, res_s2;
	logic              vld_s1, vld_s2;
	logic              adv_s2, take_in;

	nirt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Stage 1 moves on when the result register is empty or being drained
	assign adv_s2  = vld_s1 && (!vld_s2 || result.ready);
	assign take_in = item.valid && item.ready;
	assign item.ready = !vld_s1 || !vld_s2 || result.ready;

	nirt_frame_core #(
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s2),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				vld_s1 <= item.valid;
			end
			if (adv_s2) begin
				vld_s2 <= 1'b1;
			end else if (result.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// Capture the input item and the result
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.mode        <= item.mode;
			item_s1.first_byte  <= item.first_byte;
			item_s1.second_byte <= item.second_byte;
			item_s1.third_byte  <= item.third_byte;
		end
		if (adv_s2) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid           = vld_s2;
	assign result.carrier_on      = res_s2.carrier_on;
	assign result.busy_res        = res_s2.busy_res;
	assign result.receiver_enable = res_s2.receiver_enable;
	assign result.frame_done      = res_s2.frame_done;
	assign result.start_rejected  = res_s2.start_rejected;

`ifndef ASSERT_OFF
	// An item leaving stage 1 always shows up as a result on the next cycle
	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> result.valid)
		else $error("stage 1 item lost on its way to the result register");

	// The frame-end tick already reports the transmitter as free
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.frame_done) |-> (!result.busy_res && result.receiver_enable))
		else $error("frame end reported while still busy");

	// Carrier is only gated on inside a frame or on its closing tick
	a_carrier_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.carrier_on) |-> (result.busy_res || result.frame_done))
		else $error("carrier on outside a frame");

	// A rejected start never coincides with a carrier period and leaves the frame running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.start_rejected) |-> (result.busy_res && !result.carrier_on))
		else $error("start rejected while idle or during a tick");
`endif

endmodule

>>> verif/nec_ir_frame_transmitter_tb.sv
// Self-checking testbench for the NEC infrared frame transmitter.
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_tb;

	localparam int unsigned PAYLOAD_BITS = 32;
	// Result register sits two stages behind the input; allow a little over that
	localparam int SETTLE_CYCLES = 4;
	// Indexes with no register behind them; writes there must change nothing
	localparam logic [nirt_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [nirt_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	// Result field order: carrier_on, busy_res, receiver_enable, frame_done, start_rejected
	localparam nirt_pkg::result_t RES_IDLE     = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
	localparam nirt_pkg::result_t RES_STARTED  = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
	localparam nirt_pkg::result_t RES_REJECTED = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
	localparam nirt_pkg::result_t RES_MARK     = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
	localparam nirt_pkg::result_t RES_NONE     = '0;

	typedef struct packed {
		nirt_pkg::item_t   it;
		logic              typed;
		nirt_pkg::result_t want;
	} stim_row_t;

	// Directed rows, run at the reset durations
	localparam int N_ROWS = 10;
	localparam stim_row_t STIM_ROWS [N_ROWS] = '{
		'{'{nirt_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00}, 1'b1, RES_IDLE},
		'{'{nirt_pkg::MODE_TICK,  8'hFF, 8'hFF, 8'hFF}, 1'b1, RES_IDLE},
		'{'{nirt_pkg::MODE_START, 8'hFF, 8'h00, 8'hA5}, 1'b1, RES_STARTED},
		'{'{nirt_pkg::MODE_START, 8'h00, 8'hFF, 8'h5A}, 1'b1, RES_REJECTED},
		'{'{nirt_pkg::MODE_START, 8'hFF, 8'hFF, 8'hFF}, 1'b1, RES_REJECTED},
		'{'{nirt_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00}, 1'b1, RES_MARK},
		'{'{nirt_pkg::MODE_TICK,  8'hFF, 8'hFF, 8'hFF}, 1'b0, RES_NONE},
		'{'{nirt_pkg::MODE_START, 8'h00, 8'h00, 8'h00}, 1'b1, RES_REJECTED},
		'{'{nirt_pkg::MODE_TICK,  8'h3C, 8'hC3, 8'h81}, 1'b0, RES_NONE},
		'{'{nirt_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00}, 1'b0, RES_NONE}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [nirt_pkg::CFG_IDX_W-1:0] wr_index;
	logic [nirt_pkg::DUR_W-1:0]     wr_data;

	nirt_item_if in_ch();
	nirt_res_if  out_ch();

	nec_ir_frame_transmitter #(.PAYLOAD_BITS(PAYLOAD_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (in_ch),
		.result   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Frame sequencer mirror
	nirt_pkg::cfg_t             dur_cfg;
	nirt_pkg::phase_t           tx_phase;
	logic [nirt_pkg::DUR_W-1:0] period_cnt;
	logic [6:0]                 bit_idx;
	logic [63:0]                payload_word;

	nirt_pkg::result_t pending_gates [$];
	int                fault_cnt;
	int                burst_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("nec_ir_frame_transmitter: mismatch");
		$finish;
	end

	// Length of the current phase in carrier periods
	function automatic logic [nirt_pkg::DUR_W-1:0] phase_span();
		case (tx_phase)
			nirt_pkg::PH_LEAD_MARK:  return dur_cfg.leader_mark_ticks;
			nirt_pkg::PH_LEAD_SPACE: return dur_cfg.leader_space_ticks;
			nirt_pkg::PH_BIT_MARK:   return dur_cfg.bit_mark_ticks;
			nirt_pkg::PH_BIT_SPACE: begin
				if (bit_idx < 64 && payload_word[bit_idx[5:0]])
					return dur_cfg.one_space_ticks;
				return dur_cfg.zero_space_ticks;
			end
			nirt_pkg::PH_STOP_MARK:  return dur_cfg.stop_mark_ticks;
			default:                 return nirt_pkg::DUR_W'(1);
		endcase
	endfunction

	// Work out the result of one item and move the frame on
	function automatic nirt_pkg::result_t advance_frame(input nirt_pkg::item_t it);
		nirt_pkg::result_t          r;
		logic [nirt_pkg::DUR_W-1:0] span;
		r = '0;
		if (it.mode == nirt_pkg::MODE_START) begin
			if (tx_phase != nirt_pkg::PH_IDLE) begin
				r.start_rejected = 1'b1;
			end else begin
				payload_word = {32'd0, ~it.third_byte, it.third_byte, it.second_byte,
					it.first_byte};
				tx_phase = nirt_pkg::PH_LEAD_MARK;
				period_cnt = '0;
				bit_idx = '0;
			end
		end else if (tx_phase != nirt_pkg::PH_IDLE) begin
			span = phase_span();
			r.carrier_on = (tx_phase == nirt_pkg::PH_LEAD_MARK) ||
				(tx_phase == nirt_pkg::PH_BIT_MARK) || (tx_phase == nirt_pkg::PH_STOP_MARK);
			period_cnt = period_cnt + 1'b1;
			if (period_cnt >= span) begin
				period_cnt = '0;
				case (tx_phase)
					nirt_pkg::PH_LEAD_MARK:  tx_phase = nirt_pkg::PH_LEAD_SPACE;
					nirt_pkg::PH_LEAD_SPACE: tx_phase = nirt_pkg::PH_BIT_MARK;
					nirt_pkg::PH_BIT_MARK:   tx_phase = nirt_pkg::PH_BIT_SPACE;
					nirt_pkg::PH_BIT_SPACE: begin
						bit_idx = bit_idx + 1'b1;
						tx_phase = (bit_idx >= PAYLOAD_BITS) ? nirt_pkg::PH_STOP_MARK
							: nirt_pkg::PH_BIT_MARK;
					end
					nirt_pkg::PH_STOP_MARK: begin
						tx_phase = nirt_pkg::PH_IDLE;
						bit_idx = '0;
						r.frame_done = 1'b1;
					end
					default: tx_phase = nirt_pkg::PH_IDLE;
				endcase
			end
		end
		r.busy_res = (tx_phase != nirt_pkg::PH_IDLE);
		r.receiver_enable = ~r.busy_res;
		return r;
	endfunction

	// Random item: mostly starts when idle (only ticks without may_open), mostly ticks with a few stray starts when busy
	function automatic nirt_pkg::item_t rand_item(input bit may_open);
		nirt_pkg::item_t it;
		it.first_byte = 8'($urandom_range(0, 255));
		it.second_byte = 8'($urandom_range(0, 255));
		it.third_byte = 8'($urandom_range(0, 255));
		if (tx_phase == nirt_pkg::PH_IDLE)
			it.mode = (may_open && $urandom_range(0, 9) < 7) ? nirt_pkg::MODE_START
				: nirt_pkg::MODE_TICK;
		else
			it.mode = ($urandom_range(0, 99) < 3) ? nirt_pkg::MODE_START
				: nirt_pkg::MODE_TICK;
		return it;
	endfunction

	// Offer one item in bursts with random gaps; queue its expected result on transfer
	task automatic send_item(input nirt_pkg::item_t it, input logic typed,
		input nirt_pkg::result_t want);
		int                gap;
		nirt_pkg::result_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.mode <= it.mode;
		in_ch.first_byte <= it.first_byte;
		in_ch.second_byte <= it.second_byte;
		in_ch.third_byte <= it.third_byte;
		do @(posedge clk); while (!in_ch.ready);
		predicted = advance_frame(it);
		pending_gates.push_back(typed ? want : predicted);
	endtask

	// Drop valid and wait until every result is back and the pipeline has settled
	task automatic quiesce();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_gates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [nirt_pkg::CFG_IDX_W-1:0] idx,
		input logic [nirt_pkg::DUR_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			nirt_pkg::REG_LEADER_MARK:  dur_cfg.leader_mark_ticks = val;
			nirt_pkg::REG_LEADER_SPACE: dur_cfg.leader_space_ticks = val;
			nirt_pkg::REG_BIT_MARK:     dur_cfg.bit_mark_ticks = val;
			nirt_pkg::REG_ONE_SPACE:    dur_cfg.one_space_ticks = val;
			nirt_pkg::REG_ZERO_SPACE:   dur_cfg.zero_space_ticks = val;
			nirt_pkg::REG_STOP_MARK:    dur_cfg.stop_mark_ticks = val;
			default: ;
		endcase
	endtask

	task automatic set_durations(input nirt_pkg::cfg_t c);
		quiesce();
		cfg_write(nirt_pkg::REG_LEADER_MARK, c.leader_mark_ticks);
		cfg_write(nirt_pkg::REG_LEADER_SPACE, c.leader_space_ticks);
		cfg_write(nirt_pkg::REG_BIT_MARK, c.bit_mark_ticks);
		cfg_write(nirt_pkg::REG_ONE_SPACE, c.one_space_ticks);
		cfg_write(nirt_pkg::REG_ZERO_SPACE, c.zero_space_ticks);
		cfg_write(nirt_pkg::REG_STOP_MARK, c.stop_mark_ticks);
	endtask

	// Send n random items, then send more items, mostly ticks, until the frame in flight has ended
	task automatic run_random(input int n);
		repeat (n) send_item(rand_item(1'b1), 1'b0, RES_NONE);
		while (tx_phase != nirt_pkg::PH_IDLE) send_item(rand_item(1'b0), 1'b0, RES_NONE);
	endtask

	function automatic nirt_pkg::cfg_t rand_durations(input int hi);
		nirt_pkg::cfg_t c;
		c.leader_mark_ticks = nirt_pkg::DUR_W'($urandom_range(1, hi));
		c.leader_space_ticks = nirt_pkg::DUR_W'($urandom_range(1, hi));
		c.bit_mark_ticks = nirt_pkg::DUR_W'($urandom_range(1, hi));
		c.one_space_ticks = nirt_pkg::DUR_W'($urandom_range(1, hi));
		c.zero_space_ticks = nirt_pkg::DUR_W'($urandom_range(1, hi));
		c.stop_mark_ticks = nirt_pkg::DUR_W'($urandom_range(1, hi));
		return c;
	endfunction

	// Receiver: open for a while, one long hold-off to back the block up, then random stalls
	initial begin : result_sink
		int style;
		int span;
		int step;
		out_ch.ready = 1'b0;
		step = 0;
		@(posedge arst_n);
		repeat (100) begin
			@(negedge clk);
			out_ch.ready <= 1'b1;
		end
		repeat (400) begin
			@(negedge clk);
			out_ch.ready <= 1'b0;
		end
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				step++;
				case (style)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= (step % 3 != 0);
					default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Compare each transfer out with the oldest expected result
	always @(posedge clk) begin : result_check
		nirt_pkg::result_t got;
		nirt_pkg::result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.carrier_on, out_ch.busy_res, out_ch.receiver_enable,
				out_ch.frame_done, out_ch.start_rejected};
			if (pending_gates.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("%0t: result with nothing pending: %b", $realtime, got);
			end else begin
				want = pending_gates.pop_front();
				if (got.carrier_on !== want.carrier_on || got.busy_res !== want.busy_res ||
					got.receiver_enable !== want.receiver_enable ||
					got.frame_done !== want.frame_done ||
					got.start_rejected !== want.start_rejected) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("%0t: carrier/busy/rx_en/done/rej expected %b got %b",
							$realtime, want, got);
				end
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = nirt_pkg::MODE_TICK;
		in_ch.first_byte = '0;
		in_ch.second_byte = '0;
		in_ch.third_byte = '0;
		fault_cnt = 0;
		burst_left = 0;
		dur_cfg = '{nirt_pkg::RST_LEADER_MARK, nirt_pkg::RST_LEADER_SPACE,
			nirt_pkg::RST_BIT_MARK, nirt_pkg::RST_ONE_SPACE, nirt_pkg::RST_ZERO_SPACE,
			nirt_pkg::RST_STOP_MARK};
		tx_phase = nirt_pkg::PH_IDLE;
		period_cnt = '0;
		bit_idx = '0;
		payload_word = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows, then keep ticking the leader burst while the receiver holds off
		for (int k = 0; k < N_ROWS; k++)
			send_item(STIM_ROWS[k].it, STIM_ROWS[k].typed, STIM_ROWS[k].want);
		repeat (300) send_item(rand_item(1'b0), 1'b0, RES_NONE);

		// Stretch the leader burst in progress to the longest count and run the frame out
		set_durations('{10'd1023, 10'd2, 10'd1, 10'd3, 10'd1, 10'd2});
		while (tx_phase != nirt_pkg::PH_IDLE) send_item(rand_item(1'b0), 1'b0, RES_NONE);

		// Shortest legal durations
		set_durations('{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1});
		run_random(80);

		// Zero durations act as one tick; unused indexes must be ignored
		set_durations('0);
		cfg_write(REG_UNUSED_LO, 10'h3FF);
		cfg_write(REG_UNUSED_HI, 10'h155);
		run_random(60);

		// Bulk of the traffic on short random durations
		set_durations(rand_durations(3));
		run_random(150);
		set_durations(rand_durations(4));
		run_random(150);

		quiesce();
		repeat (8) @(posedge clk);
		if (fault_cnt == 0)
			$display("nec_ir_frame_transmitter: match");
		else
			$display("nec_ir_frame_transmitter: mismatch");
		$finish;
	end

endmodule
